[design/gfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfs_pkg: shared definitions for the grid fire spread step block
// Grid geometry, cell and command codes, sequencer states.
// ----------------------------------------------------------------------------
package gfs_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int COORD_W   = $clog2(MAX_WIDTH);
    localparam int IDX_W     = 2 * COORD_W;
    localparam int CELLS     = MAX_WIDTH * MAX_WIDTH;
    localparam int CNT_W     = IDX_W + 1;
    localparam int WID_W     = 7;
    localparam int CELL_W    = 2;
    localparam int KIND_W    = 2;

    localparam logic [CELL_W-1:0] CELL_EMPTY     = 2'd0;
    localparam logic [CELL_W-1:0] CELL_FIRE      = 2'd1;
    localparam logic [CELL_W-1:0] CELL_TREE      = 2'd2;
    localparam logic [CELL_W-1:0] CELL_IGNITING  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef enum logic [1:0] {
        NB_UP    = 2'd0,
        NB_DOWN  = 2'd1,
        NB_LEFT  = 2'd2,
        NB_RIGHT = 2'd3
    } nb_dir_t;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_WR_CHK = 11'b000_0000_0100,
        S_RD_OUT = 11'b000_0000_1000,
        S_L_RD   = 11'b000_0001_0000,
        S_L_CHK  = 11'b000_0010_0000,
        S_NB_RD  = 11'b000_0100_0000,
        S_NB_CHK = 11'b000_1000_0000,
        S_F_RD   = 11'b001_0000_0000,
        S_F_WR   = 11'b010_0000_0000,
        S_SPARE  = 11'b100_0000_0000
    } state_t;

endpackage : gfs_pkg
`default_nettype wire

[design/gfs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfs_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gfs_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 2
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : gfs_ram
`default_nettype wire

[design/grid_fire_spread_step_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_fire_spread_step_top: forest fire cellular automaton, one step per command
// Cell grid and a double-buffered burning list in RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Sequence: write via S_WR_CHK, read via S_RD_OUT; kind 3 and out-of-grid
//   commands finish from S_IDLE. A tick runs S_L_RD, S_L_CHK per listed entry,
//   S_NB_RD (S_NB_CHK if in grid) per neighbor, S_F_RD, S_F_WR per new fire.
// Throughput: one transaction at a time; busy stays high until done.
// Reset: a clearing pass writes every grid cell empty with busy high;
//   width resets to 50. done is a one-cycle strobe, no stall.
module grid_fire_spread_step_top
    import gfs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [KIND_W-1:0]  kind,
    input  wire logic [COORD_W-1:0] row,
    input  wire logic [COORD_W-1:0] col,
    input  wire logic [CELL_W-1:0]  cell_value,
    // result channel
    output logic                    done,
    output logic [CELL_W-1:0]       cell_read,
    output logic [CNT_W-1:0]        burning_count,
    output logic                    fire_out,
    // grid width register
    input  wire logic               cfg_we,
    input  wire logic [WID_W-1:0]   cfg_wdata
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t             state_reg,  state_next;
    logic [IDX_W-1:0]   clr_reg,    clr_next;
    logic [WID_W-1:0]   width_reg;
    logic               sel_reg,    sel_next;     // which half of list RAM is current
    logic [CNT_W-1:0]   total_reg,  total_next;   // current burning list length
    logic [CNT_W-1:0]   nt_reg,     nt_next;      // next list length during a tick
    logic [CNT_W-1:0]   k_reg,      k_next;       // list walk pointer
    logic               done_reg,   done_next;
    logic [CELL_W-1:0]  cell_read_reg, cell_read_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               fire_reg,   fire_next;

    // payload, no reset needed
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [CELL_W-1:0]  val_reg,    val_next;
    logic [IDX_W-1:0]   cur_reg,    cur_next;     // burning cell being expanded
    nb_dir_t            nb_reg,     nb_next;
    logic [IDX_W-1:0]   nb_addr_reg, nb_addr_next;

    // ------------------------------------------------------------------
    // RAMs: grid (2 bits per cell) and both burning lists in one array
    // ------------------------------------------------------------------
    logic               g_we, g_re;
    logic [IDX_W-1:0]   g_waddr, g_raddr;
    logic [CELL_W-1:0]  g_wdata, g_rdata;
    logic               l_we, l_re;
    logic [IDX_W:0]     l_waddr, l_raddr;
    logic [IDX_W-1:0]   l_wdata, l_rdata;

    gfs_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (CELL_W)
    ) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gfs_ram #(
        .ADDR_W (IDX_W + 1),
        .DATA_W (IDX_W)
    ) u_list (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    logic [WID_W-1:0]   w_used;
    logic               in_grid;
    logic [IDX_W-1:0]   idx_in;
    logic [COORD_W-1:0] cur_r, cur_c, ent_r, ent_c;
    logic               nb_ok;
    logic [IDX_W-1:0]   nb_addr;

    assign w_used  = (width_reg > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_reg;
    assign in_grid = (WID_W'(row) < w_used) && (WID_W'(col) < w_used);
    assign idx_in  = {row, col};
    assign cur_r   = cur_reg[IDX_W-1:COORD_W];
    assign cur_c   = cur_reg[COORD_W-1:0];
    assign ent_r   = l_rdata[IDX_W-1:COORD_W];
    assign ent_c   = l_rdata[COORD_W-1:0];

    // neighbor address and whether it lies inside the grid
    always_comb
    begin
        nb_ok   = 1'b0;
        nb_addr = cur_reg;
        unique case (nb_reg)
            NB_UP:
            begin
                nb_ok   = (cur_r != '0);
                nb_addr = {cur_r - COORD_W'(1), cur_c};
            end
            NB_DOWN:
            begin
                nb_ok   = ((WID_W'(cur_r) + WID_W'(1)) < w_used);
                nb_addr = {cur_r + COORD_W'(1), cur_c};
            end
            NB_LEFT:
            begin
                nb_ok   = (cur_c != '0);
                nb_addr = {cur_r, cur_c - COORD_W'(1)};
            end
            NB_RIGHT:
            begin
                nb_ok   = ((WID_W'(cur_c) + WID_W'(1)) < w_used);
                nb_addr = {cur_r, cur_c + COORD_W'(1)};
            end
            default:
            begin
                nb_ok   = 1'b0;
                nb_addr = cur_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        sel_next       = sel_reg;
        total_next     = total_reg;
        nt_next        = nt_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        nb_next        = nb_reg;
        nb_addr_next   = nb_addr_reg;
        done_next      = 1'b0;
        cell_read_next = CELL_EMPTY;
        count_next     = '0;
        fire_next      = 1'b0;

        g_re    = 1'b0;
        g_raddr = idx_in;
        g_we    = 1'b0;
        g_waddr = clr_reg;
        g_wdata = CELL_EMPTY;
        l_re    = 1'b0;
        l_raddr = {sel_reg, k_reg[IDX_W-1:0]};
        l_we    = 1'b0;
        l_waddr = {sel_reg, total_reg[IDX_W-1:0]};
        l_wdata = idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                g_we     = 1'b1;
                g_waddr  = clr_reg;
                g_wdata  = CELL_EMPTY;
                clr_next = clr_reg + IDX_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = idx_in;
                    val_next = cell_value;
                    priority if (kind == KIND_WRITE && in_grid && cell_value != CELL_IGNITING)
                    begin
                        g_re       = 1'b1;
                        g_raddr    = idx_in;
                        state_next = S_WR_CHK;
                    end
                    else if (kind == KIND_READ && in_grid)
                    begin
                        g_re       = 1'b1;
                        g_raddr    = idx_in;
                        state_next = S_RD_OUT;
                    end
                    else if (kind == KIND_TICK)
                    begin
                        k_next     = '0;
                        nt_next    = '0;
                        state_next = S_L_RD;
                    end
                    else
                    begin
                        // ignored command: empty result right away
                        done_next = 1'b1;
                    end
                end
            end

            S_WR_CHK:
            begin
                g_we    = 1'b1;
                g_waddr = idx_reg;
                g_wdata = val_reg;
                // new fire joins the list unless the list is full
                if (val_reg == CELL_FIRE && g_rdata != CELL_FIRE && !total_reg[IDX_W])
                begin
                    l_we       = 1'b1;
                    l_waddr    = {sel_reg, total_reg[IDX_W-1:0]};
                    l_wdata    = idx_reg;
                    total_next = total_reg + CNT_W'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_RD_OUT:
            begin
                cell_read_next = g_rdata;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            S_L_RD:
            begin
                if (k_reg == total_reg)
                begin
                    k_next     = '0;
                    state_next = S_F_RD;
                end
                else
                begin
                    l_re       = 1'b1;
                    l_raddr    = {sel_reg, k_reg[IDX_W-1:0]};
                    state_next = S_L_CHK;
                end
            end

            S_L_CHK:
            begin
                k_next = k_reg + CNT_W'(1);
                // stale entries outside a shrunk grid are skipped
                if (WID_W'(ent_r) < w_used && WID_W'(ent_c) < w_used)
                begin
                    g_we       = 1'b1;
                    g_waddr    = l_rdata;
                    g_wdata    = CELL_EMPTY;
                    cur_next   = l_rdata;
                    nb_next    = NB_UP;
                    state_next = S_NB_RD;
                end
                else
                begin
                    state_next = S_L_RD;
                end
            end

            S_NB_RD:
            begin
                if (nb_ok)
                begin
                    g_re         = 1'b1;
                    g_raddr      = nb_addr;
                    nb_addr_next = nb_addr;
                    state_next   = S_NB_CHK;
                end
                else if (nb_reg == NB_RIGHT)
                begin
                    state_next = S_L_RD;
                end
                else
                begin
                    nb_next = nb_dir_t'(nb_reg + 2'd1);
                end
            end

            S_NB_CHK:
            begin
                if (g_rdata == CELL_TREE)
                begin
                    g_we    = 1'b1;
                    g_waddr = nb_addr_reg;
                    g_wdata = CELL_IGNITING;
                    if (!nt_reg[IDX_W])
                    begin
                        l_we    = 1'b1;
                        l_waddr = {~sel_reg, nt_reg[IDX_W-1:0]};
                        l_wdata = nb_addr_reg;
                        nt_next = nt_reg + CNT_W'(1);
                    end
                end
                if (nb_reg == NB_RIGHT)
                begin
                    state_next = S_L_RD;
                end
                else
                begin
                    nb_next    = nb_dir_t'(nb_reg + 2'd1);
                    state_next = S_NB_RD;
                end
            end

            S_F_RD:
            begin
                if (k_reg == nt_reg)
                begin
                    // swap lists and report
                    total_next = nt_reg;
                    sel_next   = ~sel_reg;
                    count_next = nt_reg;
                    fire_next  = (nt_reg == '0);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    l_re       = 1'b1;
                    l_raddr    = {~sel_reg, k_reg[IDX_W-1:0]};
                    state_next = S_F_WR;
                end
            end

            S_F_WR:
            begin
                g_we       = 1'b1;
                g_waddr    = l_rdata;
                g_wdata    = CELL_FIRE;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_F_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            width_reg     <= WID_W'(50);
            sel_reg       <= 1'b0;
            total_reg     <= '0;
            nt_reg        <= '0;
            k_reg         <= '0;
            done_reg      <= 1'b0;
            cell_read_reg <= CELL_EMPTY;
            count_reg     <= '0;
            fire_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sel_reg       <= sel_next;
            total_reg     <= total_next;
            nt_reg        <= nt_next;
            k_reg         <= k_next;
            done_reg      <= done_next;
            cell_read_reg <= cell_read_next;
            count_reg     <= count_next;
            fire_reg      <= fire_next;
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        nb_reg      <= nb_next;
        nb_addr_reg <= nb_addr_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign cell_read     = cell_read_reg;
    assign burning_count = count_reg;
    assign fire_out      = fire_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither in progress nor finished");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg <= CNT_W'(CELLS)) && (nt_reg <= CNT_W'(CELLS)))
        else $error("burning list length beyond capacity");

    a_fire_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire_out |-> (done && burning_count == '0))
        else $error("fire_out without done or with nonzero count");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F_WR) |-> (k_reg < nt_reg))
        else $error("fire pass beyond next list");

endmodule : grid_fire_spread_step_top
`default_nettype wire

[verif/grid_fire_spread_step_checker.sv]
// ----------------------------------------------------------------------------
// grid_fire_spread_step_checker: scoreboard for the fire spread block
// Mirrors grid, burning lists and width; predicts each command's result
// and compares it with the done strobe, oldest first.
// ----------------------------------------------------------------------------
module grid_fire_spread_step_checker
    import gfs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [KIND_W-1:0]  kind,
    input  wire logic [COORD_W-1:0] row,
    input  wire logic [COORD_W-1:0] col,
    input  wire logic [CELL_W-1:0]  cell_value,
    input  wire logic               done,
    input  wire logic [CELL_W-1:0]  cell_read,
    input  wire logic [CNT_W-1:0]   burning_count,
    input  wire logic               fire_out,
    input  wire logic               cfg_we,
    input  wire logic [WID_W-1:0]   cfg_wdata,
    output int                      pending,
    output int                      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [CNT_W-1:0]  count;
        logic              extinguished;
    } fire_result_t;

    logic [CELL_W-1:0] grid_mem  [CELLS];
    int unsigned       fire_list [CELLS];
    int unsigned       next_list [CELLS];
    int unsigned       fire_cnt;
    int unsigned       next_cnt;
    logic [WID_W-1:0]  width_reg;
    fire_result_t      expected_q [$];

    function automatic int unsigned eff_width();
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < CELLS; i++)
            grid_mem[i] = CELL_EMPTY;
        fire_cnt  = 0;
        next_cnt  = 0;
        width_reg = 7'd50;
    endfunction

    function automatic void catch_fire(input int unsigned idx);
        if (grid_mem[idx] == CELL_TREE)
        begin
            grid_mem[idx] = CELL_IGNITING;
            if (next_cnt < CELLS)
            begin
                next_list[next_cnt] = idx;
                next_cnt++;
            end
        end
    endfunction

    function automatic int unsigned spread_tick();
        int unsigned w;
        int unsigned idx;
        int unsigned r;
        int unsigned c;
        w        = eff_width();
        next_cnt = 0;
        for (int unsigned k = 0; k < fire_cnt; k++)
        begin
            idx = fire_list[k];
            r   = idx / MAX_WIDTH;
            c   = idx % MAX_WIDTH;
            // entries left outside a shrunken grid are skipped
            if (r < w && c < w)
            begin
                grid_mem[idx] = CELL_EMPTY;
                if (r > 0)     catch_fire(idx - MAX_WIDTH);
                if (r + 1 < w) catch_fire(idx + MAX_WIDTH);
                if (c > 0)     catch_fire(idx - 1);
                if (c + 1 < w) catch_fire(idx + 1);
            end
        end
        for (int unsigned k = 0; k < next_cnt; k++)
        begin
            grid_mem[next_list[k]] = CELL_FIRE;
            fire_list[k] = next_list[k];
        end
        fire_cnt = next_cnt;
        return next_cnt;
    endfunction

    function automatic fire_result_t predict_cmd(input logic [KIND_W-1:0]  k,
                                                 input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c,
                                                 input logic [CELL_W-1:0]  v);
        fire_result_t res;
        int unsigned  w;
        int unsigned  idx;
        int unsigned  n;
        logic         in_grid;
        res     = '0;
        w       = eff_width();
        in_grid = (r < w) && (c < w);
        idx     = r * MAX_WIDTH + c;
        case (k)
            KIND_WRITE:
            begin
                if (in_grid && v != CELL_IGNITING)
                begin
                    if (v == CELL_FIRE && grid_mem[idx] != CELL_FIRE && fire_cnt < CELLS)
                    begin
                        fire_list[fire_cnt] = idx;
                        fire_cnt++;
                    end
                    grid_mem[idx] = v;
                end
            end
            KIND_TICK:
            begin
                n                = spread_tick();
                res.count        = n[CNT_W-1:0];
                res.extinguished = (n == 0);
            end
            KIND_READ:
            begin
                if (in_grid)
                    res.cell_val = grid_mem[idx];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_result();
        fire_result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result cell_read=%0d burning_count=%0d fire_out=%0d",
                     $time, cell_read, burning_count, fire_out);
            fail_count++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (cell_read !== want.cell_val)
            begin
                $display("%0t: cell_read expected %0d actual %0d",
                         $time, want.cell_val, cell_read);
                fail_count++;
            end
            if (burning_count !== want.count)
            begin
                $display("%0t: burning_count expected %0d actual %0d",
                         $time, want.count, burning_count);
                fail_count++;
            end
            if (fire_out !== want.extinguished)
            begin
                $display("%0t: fire_out expected %0d actual %0d",
                         $time, want.extinguished, fire_out);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (done)
                check_result();
            if (cfg_we)
                width_reg = cfg_wdata;
            if (start && !busy)
                expected_q.push_back(predict_cmd(kind, row, col, cell_value));
        end
        pending = expected_q.size();
    end

endmodule : grid_fire_spread_step_checker

[verif/grid_fire_spread_step_top_tb.sv]
// ----------------------------------------------------------------------------
// grid_fire_spread_step_top_tb: testbench for the fire spread step block
// Directed corner cases, then random phases of forest burns, reads, writes
// and ticks across several grid widths; results checked by the checker.
// ----------------------------------------------------------------------------
module grid_fire_spread_step_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gfs_pkg::*;

    // kind 3 has no package name: the block treats it as a no-op
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int RAND_ITEMS    = 500;
    localparam int SETTLE_CYCLES = 32;
    // clearing pass after reset plus worst-case ticks, with wide margin
    localparam int CYCLE_LIMIT   = 1_500_000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CELL_W-1:0]  cell_value;
    logic               done;
    logic [CELL_W-1:0]  cell_read;
    logic [CNT_W-1:0]   burning_count;
    logic               fire_out;
    logic               cfg_we;
    logic [WID_W-1:0]   cfg_wdata;
    int                 pending;
    int                 fail_count;

    int unsigned        sent_items = 0;  // transactions sent, no-ops excluded
    int unsigned        gap_max    = 0;  // 0 gives back-to-back commands
    int unsigned        grid_w     = 50; // width in effect, clipped to MAX_WIDTH
    int unsigned        cycles     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grid_fire_spread_step_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .cell_value    (cell_value),
        .done          (done),
        .cell_read     (cell_read),
        .burning_count (burning_count),
        .fire_out      (fire_out),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    grid_fire_spread_step_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .cell_value    (cell_value),
        .done          (done),
        .cell_read     (cell_read),
        .burning_count (burning_count),
        .fire_out      (fire_out),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Issue one transaction. Called at a falling edge; returns at the falling
    // edge after acceptance with start still high, so a back-to-back command
    // just overwrites the fields and start is never dropped and re-raised.
    task automatic send_cmd(input logic [KIND_W-1:0]  k,
                            input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c,
                            input logic [CELL_W-1:0]  v);
        int unsigned gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        row        <= r;
        col        <= c;
        cell_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (k != KIND_NOP)
            sent_items++;
    endtask

    // Hold off until every outstanding transaction has its result and the
    // block is idle (this also rides out the clearing pass after reset).
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    // Width is only changed with the block idle.
    task automatic set_width(input logic [WID_W-1:0] w);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        grid_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    endtask

    // Mostly inside the grid; now and then anywhere, to hit out-of-grid cases.
    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom_range(0, MAX_WIDTH - 1));
        return COORD_W'($urandom_range(0, grid_w - 1));
    endfunction

    // A small patch of forest, one or two fires set in it, then a few ticks
    // with reads of the patch. Ticks carry junk coordinates: they are unused.
    task automatic burn_patch();
        int unsigned span;
        int unsigned r0;
        int unsigned c0;
        int unsigned n_trees;
        int unsigned n_ticks;
        logic [CELL_W-1:0] v;
        span = $urandom_range(3, 6);
        if (span > grid_w)
            span = grid_w;
        r0      = $urandom_range(0, grid_w - span);
        c0      = $urandom_range(0, grid_w - span);
        n_trees = $urandom_range(2, (span * span > 14) ? 14 : span * span);
        repeat (n_trees)
        begin
            // mostly trees, some stray values including the invalid one
            v = ($urandom_range(0, 7) == 0) ? CELL_W'($urandom_range(0, 3)) : CELL_TREE;
            send_cmd(KIND_WRITE, COORD_W'(r0 + $urandom_range(0, span - 1)),
                     COORD_W'(c0 + $urandom_range(0, span - 1)), v);
        end
        repeat ($urandom_range(1, 2))
            send_cmd(KIND_WRITE, COORD_W'(r0 + $urandom_range(0, span - 1)),
                     COORD_W'(c0 + $urandom_range(0, span - 1)), CELL_FIRE);
        n_ticks = $urandom_range(1, 6);
        repeat (n_ticks)
        begin
            send_cmd(KIND_TICK, COORD_W'($urandom_range(0, 63)),
                     COORD_W'($urandom_range(0, 63)), CELL_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 1)
                send_cmd(KIND_READ, COORD_W'(r0 + $urandom_range(0, span - 1)),
                         COORD_W'(c0 + $urandom_range(0, span - 1)),
                         CELL_W'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        int unsigned base_items;
        int unsigned phase;
        int unsigned phase_end;
        int unsigned pick;
        logic [WID_W-1:0] wcfg;

        start      = 1'b0;
        kind       = KIND_WRITE;
        row        = '0;
        col        = '0;
        cell_value = CELL_EMPTY;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        rst_n      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        drain_results();

        // ---- directed part ----
        // default width 50: fresh grid reads empty, edge cell in grid
        send_cmd(KIND_READ,  6'd0,  6'd0,  CELL_EMPTY);
        send_cmd(KIND_WRITE, 6'd49, 6'd49, CELL_TREE);
        send_cmd(KIND_READ,  6'd49, 6'd49, CELL_EMPTY);
        // row 50 is outside the default grid: write dropped, read gives 0
        send_cmd(KIND_WRITE, 6'd50, 6'd3,  CELL_TREE);
        send_cmd(KIND_READ,  6'd50, 6'd3,  CELL_EMPTY);
        // invalid write value is ignored
        send_cmd(KIND_WRITE, 6'd1,  6'd1,  CELL_IGNITING);
        send_cmd(KIND_READ,  6'd1,  6'd1,  CELL_EMPTY);
        // no-op with all field bits set
        send_cmd(KIND_NOP,   6'd63, 6'd63, CELL_IGNITING);
        // tick on an empty list: fire is out
        send_cmd(KIND_TICK,  6'd0,  6'd0,  CELL_EMPTY);

        // width above the maximum acts as 64: far corner usable
        set_width(7'd127);
        send_cmd(KIND_WRITE, 6'd62, 6'd63, CELL_TREE);
        send_cmd(KIND_WRITE, 6'd63, 6'd62, CELL_TREE);
        send_cmd(KIND_WRITE, 6'd63, 6'd63, CELL_FIRE);
        // overwrite a burning cell, then set it burning again (second entry)
        send_cmd(KIND_WRITE, 6'd63, 6'd63, CELL_TREE);
        send_cmd(KIND_WRITE, 6'd63, 6'd63, CELL_FIRE);
        send_cmd(KIND_TICK,  6'd0,  6'd0,  CELL_EMPTY);
        send_cmd(KIND_READ,  6'd62, 6'd63, CELL_EMPTY);
        send_cmd(KIND_READ,  6'd63, 6'd63, CELL_EMPTY);
        send_cmd(KIND_TICK,  6'd63, 6'd63, CELL_IGNITING);

        // stale list entry after the grid shrinks is skipped on a tick
        send_cmd(KIND_WRITE, 6'd40, 6'd40, CELL_FIRE);
        send_cmd(KIND_WRITE, 6'd40, 6'd41, CELL_TREE);
        set_width(7'd10);
        send_cmd(KIND_TICK,  6'd0,  6'd0,  CELL_EMPTY);
        send_cmd(KIND_READ,  6'd40, 6'd40, CELL_EMPTY);
        set_width(7'd64);
        send_cmd(KIND_READ,  6'd40, 6'd40, CELL_EMPTY);
        send_cmd(KIND_READ,  6'd40, 6'd41, CELL_EMPTY);

        // ---- random phases, one width each ----
        base_items = sent_items;
        phase      = 0;
        while (sent_items < base_items + RAND_ITEMS)
        begin
            case (phase)
                0:       wcfg = 7'd2;
                1:       wcfg = 7'd64;
                2:       wcfg = 7'd127;
                default:
                begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        wcfg = WID_W'($urandom_range(65, 127));
                    else if (pick == 1)
                        wcfg = WID_W'($urandom_range(2, 12));
                    else
                        wcfg = WID_W'($urandom_range(2, 64));
                end
            endcase
            set_width(wcfg);
            // some phases run back to back, the rest with random gaps
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 11;
            phase_end = sent_items + $urandom_range(40, 90);
            while (sent_items < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    burn_patch();
                else if (pick < 75)
                    send_cmd(KIND_READ, pick_coord(), pick_coord(),
                             CELL_W'($urandom_range(0, 3)));
                else if (pick < 90)
                    send_cmd(KIND_WRITE, pick_coord(), pick_coord(),
                             CELL_W'($urandom_range(0, 3)));
                else if (pick < 95)
                    send_cmd(KIND_TICK, COORD_W'($urandom_range(0, 63)),
                             COORD_W'($urandom_range(0, 63)), CELL_W'($urandom_range(0, 3)));
                else if (pick < 98)
                    send_cmd(KIND_NOP, COORD_W'($urandom_range(0, 63)),
                             COORD_W'($urandom_range(0, 63)), CELL_W'($urandom_range(0, 3)));
                else
                    drain_results();
            end
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule : grid_fire_spread_step_top_tb
